// File: rtl/lmlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmlt_pkg
// Shared types, constants and codes of the LCD mode and line timing block.
// ----------------------------------------------------------------------------
package lmlt_pkg;

    localparam int DOT_W  = 9;
    localparam int LINE_W = 8;
    localparam int OFF_W  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [DOT_W-1:0]  DOTS_PER_LINE     = DOT_W'(456);
    localparam logic [DOT_W-1:0]  DOT_MAX           = '1;
    localparam logic [DOT_W-1:0]  OAM_END_DOT       = DOT_W'(80);
    localparam logic [DOT_W-1:0]  XFER_END_DOT      = DOT_W'(252);
    localparam logic [LINE_W-1:0] VBLANK_FIRST_LINE = LINE_W'(144);
    localparam logic [LINE_W-1:0] LINES_PER_FRAME   = LINE_W'(154);
    localparam logic [OFF_W-1:0]  OFF_EVENT_PERIOD  = OFF_W'(9120);

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_lcd_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LCD_ENABLE   = 3'd0,
        CFG_LINE_COMPARE = 3'd1,
        CFG_HBLANK_IE    = 3'd2,
        CFG_VBLANK_IE    = 3'd3,
        CFG_OAM_IE       = 3'd4,
        CFG_MATCH_IE     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              lcd_enable;
        logic [LINE_W-1:0] line_compare;
        logic              hblank_irq_enable;
        logic              vblank_stat_enable;
        logic              oam_irq_enable;
        logic              match_irq_enable;
    } t_cfg;

    typedef struct packed {
        t_lcd_mode         lcd_mode;
        logic [LINE_W-1:0] line_number;
        logic              match_flag;
        logic              stat_irq;
        logic              vblank_irq;
        logic              render_req;
        logic [LINE_W-1:0] render_line;
        logic              hdma_req;
        logic              frame_done;
        logic              off_event;
    } t_result;

endpackage

// File: rtl/lmlt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmlt channel interfaces
// Tick input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface lmlt_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface lmlt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] lcd_mode;
    logic [7:0] line_number;
    logic       match_flag;
    logic       stat_irq;
    logic       vblank_irq;
    logic       render_req;
    logic [7:0] render_line;
    logic       hdma_req;
    logic       frame_done;
    logic       off_event;

    modport source (output valid, output lcd_mode, output line_number, output match_flag,
                    output stat_irq, output vblank_irq, output render_req,
                    output render_line, output hdma_req, output frame_done,
                    output off_event, input ready);
    modport sink   (input valid, input lcd_mode, input line_number, input match_flag,
                    input stat_irq, input vblank_irq, input render_req,
                    input render_line, input hdma_req, input frame_done,
                    input off_event, output ready);
endinterface

interface lmlt_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lmlt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmlt_cfg
// Configuration register file, written one word per handshake.
// ----------------------------------------------------------------------------
module lmlt_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [lmlt_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [lmlt_pkg::CFG_DATA_W-1:0] i_data,
    output lmlt_pkg::t_cfg                 o_cfg
);
    import lmlt_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (t_cfg_idx'(i_idx))
                CFG_LCD_ENABLE:   n_cfg.lcd_enable         = i_data[0];
                CFG_LINE_COMPARE: n_cfg.line_compare       = i_data[LINE_W-1:0];
                CFG_HBLANK_IE:    n_cfg.hblank_irq_enable  = i_data[0];
                CFG_VBLANK_IE:    n_cfg.vblank_stat_enable = i_data[0];
                CFG_OAM_IE:       n_cfg.oam_irq_enable     = i_data[0];
                CFG_MATCH_IE:     n_cfg.match_irq_enable   = i_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{lcd_enable: 1'b1, line_compare: '0, default: 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/lmlt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmlt_core
// Dot, line, mode, coincidence and off-period state; forms one result word
// per accepted tick word.
// ----------------------------------------------------------------------------
module lmlt_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_tick,
    input  lmlt_pkg::t_cfg    i_cfg,
    output lmlt_pkg::t_result o_result
);
    import lmlt_pkg::*;

    logic [DOT_W-1:0]  r_dot,   n_dot;
    logic [LINE_W-1:0] r_line,  n_line;
    t_lcd_mode         r_mode,  n_mode;
    logic              r_match, n_match;
    logic [OFF_W-1:0]  r_off,   n_off;

    logic [DOT_W-1:0]  dot_inc;
    logic [LINE_W-1:0] line_inc;
    logic [OFF_W-1:0]  off_inc;
    logic              inc_match;
    logic              zero_match;
    logic              line_end;
    t_result           res;

    assign dot_inc    = (r_dot != DOT_MAX) ? r_dot + DOT_W'(1) : r_dot;
    assign line_inc   = r_line + LINE_W'(1);
    assign off_inc    = r_off + OFF_W'(1);
    assign inc_match  = (line_inc == i_cfg.line_compare);
    assign zero_match = (i_cfg.line_compare == '0);
    assign line_end   = (dot_inc >= DOTS_PER_LINE);

    always_comb begin
        n_dot   = r_dot;
        n_line  = r_line;
        n_mode  = r_mode;
        n_match = r_match;
        n_off   = r_off;
        res     = '0;
        if (i_tick) begin
            if (!i_cfg.lcd_enable) begin
                n_off         = (off_inc == OFF_EVENT_PERIOD) ? '0 : off_inc;
                res.off_event = (off_inc == OFF_EVENT_PERIOD);
            end else begin
                n_dot = dot_inc;
                unique case (r_mode)
                    MODE_HBLANK: begin
                        if (line_end) begin
                            res.render_req  = 1'b1;
                            res.render_line = r_line;
                            res.hdma_req    = 1'b1;
                            n_line          = line_inc;
                            n_match         = inc_match;
                            res.stat_irq    = inc_match & i_cfg.match_irq_enable;
                            if (line_inc == VBLANK_FIRST_LINE) begin
                                res.stat_irq   = res.stat_irq | i_cfg.vblank_stat_enable;
                                res.vblank_irq = 1'b1;
                                n_mode         = MODE_VBLANK;
                            end else begin
                                res.stat_irq = res.stat_irq | i_cfg.oam_irq_enable;
                                n_mode       = MODE_OAM;
                            end
                            n_dot = '0;
                        end
                    end
                    MODE_VBLANK: begin
                        if (line_end) begin
                            res.stat_irq = inc_match & i_cfg.match_irq_enable;
                            if (line_inc == LINES_PER_FRAME) begin
                                res.frame_done = 1'b1;
                                n_line         = '0;
                                n_match        = zero_match;
                                res.stat_irq   = res.stat_irq | i_cfg.oam_irq_enable
                                               | (zero_match & i_cfg.match_irq_enable);
                                n_mode         = MODE_OAM;
                            end else begin
                                n_line  = line_inc;
                                n_match = inc_match;
                            end
                            n_dot = '0;
                        end
                    end
                    MODE_OAM: begin
                        if (dot_inc >= OAM_END_DOT) begin
                            n_mode = MODE_XFER;
                        end
                    end
                    MODE_XFER: begin
                        if (dot_inc >= XFER_END_DOT) begin
                            n_mode       = MODE_HBLANK;
                            res.stat_irq = i_cfg.hblank_irq_enable;
                        end
                    end
                    default: n_mode = r_mode;
                endcase
            end
        end
        res.lcd_mode    = n_mode;
        res.line_number = n_line;
        res.match_flag  = n_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot   <= '0;
            r_line  <= '0;
            r_mode  <= MODE_OAM;
            r_match <= 1'b0;
            r_off   <= '0;
        end else if (i_accept) begin
            r_dot   <= n_dot;
            r_line  <= n_line;
            r_mode  <= n_mode;
            r_match <= n_match;
            r_off   <= n_off;
        end
    end

    assign o_result = res;

endmodule

// File: rtl/lmlt_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmlt_skid
// Result register with a skid stage; input ready depends only on local state.
// ----------------------------------------------------------------------------
module lmlt_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lmlt_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output lmlt_pkg::t_result o_data
);
    import lmlt_pkg::*;

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    in_fire;
    logic    out_fire;

    assign o_ready  = !r_skid_v;
    assign in_fire  = i_valid && !r_skid_v;
    assign out_fire = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (in_fire) begin
            if (!r_out_v || out_fire) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (out_fire) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (!r_out_v || out_fire) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (out_fire && r_skid_v) begin
            r_out <= r_skid;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

// File: rtl/lcd_mode_line_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_line_timing
// LCD mode and scan line timing, one dot-clock tick word per input word.
// Result words are registered; the skid register holds one while output stalls.
// One word per cycle while the skid register is empty; state updates on accept.
// Reset (synchronous, active low): line 0, dot 0, OAM scan mode, display
// enabled, interrupt enables and compare cleared, output buffer empty.
// ----------------------------------------------------------------------------
module lcd_mode_line_timing (
    input  logic i_clk,
    input  logic i_rst_n,
    lmlt_in_if.sink    i_in,
    lmlt_out_if.source o_out,
    lmlt_cfg_if.sink   i_cfg
);
    import lmlt_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_result out_data;
    logic    in_ready;
    logic    accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign accept      = i_in.valid && in_ready;

    lmlt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    lmlt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_tick   (i_in.tick),
        .i_cfg    (cfg),
        .o_result (result)
    );

    lmlt_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (in_ready),
        .i_data  (result),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (out_data)
    );

    assign o_out.lcd_mode    = out_data.lcd_mode;
    assign o_out.line_number = out_data.line_number;
    assign o_out.match_flag  = out_data.match_flag;
    assign o_out.stat_irq    = out_data.stat_irq;
    assign o_out.vblank_irq  = out_data.vblank_irq;
    assign o_out.render_req  = out_data.render_req;
    assign o_out.render_line = out_data.render_line;
    assign o_out.hdma_req    = out_data.hdma_req;
    assign o_out.frame_done  = out_data.frame_done;
    assign o_out.off_event   = out_data.off_event;

endmodule

// File: tb/sv/lcd_mode_line_timing_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_line_timing_tb
// Self-checking bench for the LCD mode and line timing block. A cycle-level
// predictor tracks dot, line, mode, coincidence and display-off counters and
// builds one expected status word per accepted tick word. Directed checks
// cover reset state and register extremes. A walk over the first scan lines
// crosses every mode change within a line and the line ends. A display-off
// run advances the off counter. Random bursts with register writes between
// them close out the run.
// ----------------------------------------------------------------------------
module lcd_mode_line_timing_tb;
    import lmlt_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_WORDS = 450;
    localparam int OFF_WORDS_PER_PHASE = 100;

    logic i_clk;
    logic i_rst_n;

    lmlt_in_if  in_if ();
    lmlt_out_if out_if ();
    lmlt_cfg_if cfg_if ();

    lcd_mode_line_timing dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // timing model state
    logic [DOT_W-1:0]  dot_q;
    logic [LINE_W-1:0] line_q;
    t_lcd_mode         mode_q;
    logic              match_q;
    logic [OFF_W-1:0]  off_q;
    t_cfg              cfg_q;
    int                frames_seen;

    t_result status_q[$];
    int      error_count;
    int      cycle_count;
    int      tx_idle_pct;
    int      rx_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic set_idling(input int phase);
        case (phase)
            0: begin
                tx_idle_pct = 21;
                rx_idle_pct = 47;
            end
            1: begin
                tx_idle_pct = 47;
                rx_idle_pct = 21;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    function automatic logic load_line(input logic [LINE_W-1:0] ln);
        line_q = ln;
        match_q = (ln == cfg_q.line_compare);
        return match_q & cfg_q.match_irq_enable;
    endfunction

    function automatic t_result advance_timing(input logic tick);
        t_result r;
        logic    stat;
        r = '0;
        stat = 1'b0;
        if (tick) begin
            if (!cfg_q.lcd_enable) begin
                off_q = (off_q == OFF_EVENT_PERIOD - 1) ? '0 : off_q + 1'b1;
                r.off_event = (off_q == '0);
            end else begin
                if (dot_q != DOT_MAX) dot_q = dot_q + 1'b1;
                case (mode_q)
                    MODE_HBLANK: begin
                        if (dot_q >= DOTS_PER_LINE) begin
                            r.render_req = 1'b1;
                            r.render_line = line_q;
                            r.hdma_req = 1'b1;
                            stat |= load_line(LINE_W'(line_q + 1));
                            if (line_q == VBLANK_FIRST_LINE) begin
                                stat |= cfg_q.vblank_stat_enable;
                                r.vblank_irq = 1'b1;
                                mode_q = MODE_VBLANK;
                            end else begin
                                mode_q = MODE_OAM;
                                stat |= cfg_q.oam_irq_enable;
                            end
                            dot_q = '0;
                        end
                    end
                    MODE_VBLANK: begin
                        if (dot_q >= DOTS_PER_LINE) begin
                            stat |= load_line(LINE_W'(line_q + 1));
                            if (line_q == LINES_PER_FRAME) begin
                                r.frame_done = 1'b1;
                                stat |= load_line('0);
                                mode_q = MODE_OAM;
                                stat |= cfg_q.oam_irq_enable;
                                frames_seen++;
                            end
                            dot_q = '0;
                        end
                    end
                    MODE_OAM: begin
                        if (dot_q >= OAM_END_DOT) mode_q = MODE_XFER;
                    end
                    default: begin
                        if (dot_q >= XFER_END_DOT) begin
                            mode_q = MODE_HBLANK;
                            stat |= cfg_q.hblank_irq_enable;
                        end
                    end
                endcase
            end
        end
        r.lcd_mode = mode_q;
        r.line_number = line_q;
        r.match_flag = match_q;
        r.stat_irq = stat;
        return r;
    endfunction

    // call at a falling edge; returns at a falling edge with valid still high
    task automatic send_tick(input logic tick);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.tick <= tick;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        status_q.push_back(advance_timing(tick));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_LCD_ENABLE:   cfg_q.lcd_enable = data[0];
            CFG_LINE_COMPARE: cfg_q.line_compare = data;
            CFG_HBLANK_IE:    cfg_q.hblank_irq_enable = data[0];
            CFG_VBLANK_IE:    cfg_q.vblank_stat_enable = data[0];
            CFG_OAM_IE:       cfg_q.oam_irq_enable = data[0];
            CFG_MATCH_IE:     cfg_q.match_irq_enable = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : status_check
        t_result want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (status_q.size() == 0) begin
                $display("%0t: unexpected status word, expected none, actual mode %0d line %0d",
                         $time, out_if.lcd_mode, out_if.line_number);
                error_count++;
            end else begin
                want = status_q.pop_front();
                check_field("lcd_mode", 8'(want.lcd_mode), 8'(out_if.lcd_mode));
                check_field("line_number", want.line_number, out_if.line_number);
                check_field("match_flag", 8'(want.match_flag), 8'(out_if.match_flag));
                check_field("stat_irq", 8'(want.stat_irq), 8'(out_if.stat_irq));
                check_field("vblank_irq", 8'(want.vblank_irq), 8'(out_if.vblank_irq));
                check_field("render_req", 8'(want.render_req), 8'(out_if.render_req));
                check_field("render_line", want.render_line, out_if.render_line);
                check_field("hdma_req", 8'(want.hdma_req), 8'(out_if.hdma_req));
                check_field("frame_done", 8'(want.frame_done), 8'(out_if.frame_done));
                check_field("off_event", 8'(want.off_event), 8'(out_if.off_event));
            end
        end
    end

    task automatic test_reset_defaults();
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_register_extremes();
        for (int i = CFG_LCD_ENABLE; i <= CFG_MATCH_IE; i++) begin
            write_reg(t_cfg_idx'(i), 8'hFF);
        end
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);
        // even data clears the enable bit
        write_reg(CFG_LCD_ENABLE, 8'hFE);
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);
        for (int i = CFG_LCD_ENABLE; i <= CFG_MATCH_IE; i++) begin
            write_reg(t_cfg_idx'(i), 8'h00);
        end
        write_reg(CFG_LCD_ENABLE, 8'h01);
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_display_off();
        write_reg(CFG_LCD_ENABLE, 8'h00);
        for (int ph = 0; ph < 3; ph++) begin
            set_idling(ph);
            for (int n = 0; n < OFF_WORDS_PER_PHASE; n++) begin
                send_tick($urandom_range(99) != 0);
            end
            write_reg(CFG_LINE_COMPARE, 8'($urandom_range(255)));
        end
        write_reg(CFG_LCD_ENABLE, 8'h01);
        repeat (3) send_tick(1'b1);
    endtask

    task automatic test_frame_walk();
        int                    chunk;
        int                    len;
        logic [LINE_W-1:0]     cmp;
        logic [CFG_DATA_W-1:0] vb;
        chunk = 0;
        frames_seen = 0;
        while (line_q < 2) begin
            case ($urandom_range(4))
                0: cmp = LINE_W'(line_q + 1);
                1: cmp = '0;
                2: cmp = LINES_PER_FRAME;
                3: cmp = VBLANK_FIRST_LINE;
                default: cmp = LINE_W'($urandom_range(255));
            endcase
            // catch the transient line before the wrap
            if (frames_seen == 0 && line_q >= 149) cmp = LINES_PER_FRAME;
            vb = 8'($urandom_range(255));
            if (line_q >= 140 && line_q <= 143) vb[0] = 1'b1;
            write_reg(CFG_LCD_ENABLE, {7'($urandom_range(127)), 1'b1});
            write_reg(CFG_LINE_COMPARE, cmp);
            write_reg(CFG_HBLANK_IE, 8'($urandom_range(255)));
            write_reg(CFG_VBLANK_IE, vb);
            write_reg(CFG_OAM_IE, 8'($urandom_range(255)));
            write_reg(CFG_MATCH_IE, (frames_seen == 0 && line_q >= 149) ? 8'h01
                                                                         : 8'($urandom_range(255)));
            set_idling(chunk % 3);
            len = $urandom_range(100, 300);
            for (int n = 0; n < len; n++) begin
                send_tick($urandom_range(19) != 0);
            end
            chunk++;
        end
    endtask

    task automatic test_random_traffic();
        int sent;
        int len;
        int idx;
        logic [CFG_DATA_W-1:0] data;
        for (int ph = 0; ph < 3; ph++) begin
            set_idling(ph);
            sent = 0;
            while (sent < RANDOM_WORDS / 3) begin
                len = $urandom_range(1, 120);
                for (int n = 0; n < len; n++) begin
                    send_tick($urandom_range(99) < 85);
                end
                sent += len;
                if ($urandom_range(1) == 0) begin
                    idx = $urandom_range(CFG_MATCH_IE);
                    case ($urandom_range(3))
                        0: data = 8'h00;
                        1: data = 8'hFF;
                        default: data = 8'($urandom_range(255));
                    endcase
                    if (idx == CFG_LCD_ENABLE) data[0] = ($urandom_range(3) != 0);
                    write_reg(t_cfg_idx'(idx), data);
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.tick = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_LCD_ENABLE;
        cfg_if.data = '0;
        dot_q = '0;
        line_q = '0;
        mode_q = MODE_OAM;
        match_q = 1'b0;
        off_q = '0;
        cfg_q = '0;
        cfg_q.lcd_enable = 1'b1;
        frames_seen = 0;
        error_count = 0;
        cycle_count = 0;
        set_idling(0);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_frame_walk();
        test_display_off();
        test_random_traffic();

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
